>>> src/tgarle_pkg.sv
// ---------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ---------------------------------------------------------------------------
package tgarle_pkg;

   // configuration register indexes
   localparam logic CSR_PIXEL_TOTAL = 1'b0;
   localparam logic CSR_PIXEL_BYTES = 1'b1;

   localparam int CSR_DATA_WIDTH = 32;

   // reset values of the configuration registers
   localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd1;
   localparam logic [2:0]  PIXEL_BYTES_RESET = 3'd3;

   // pixel size code that selects four-byte pixels
   localparam logic [2:0]  PIXEL_BYTES_RGBA = 3'd4;

   // run offset: a run header minus this value gives the run's pixel count
   localparam logic [7:0]  RUN_OFFSET = 8'd127;

   // byte word held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_word_type;

   // one decoded pixel result
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       last_pixel;
      logic       overrun;
   } pixel_type;

endpackage

>>> src/tgarle_in_stage.sv
// ---------------------------------------------------------------------------
// tgarle_in_stage
// Input register: holds one accepted byte word until the core takes it.
// ---------------------------------------------------------------------------
module tgarle_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      take,
   output tgarle_pkg::byte_word_type word
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       load;

   // free when empty or when the core takes the held word this cycle
   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !take);
   assign data_in   = load ? req_data_byte : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign word.valid = valid_ff;
   assign word.data  = data_ff;

endmodule

>>> src/tgarle_core.sv
// ---------------------------------------------------------------------------
// tgarle_core
// Packet state, pixel assembly and image pixel counting for one byte word.
// ---------------------------------------------------------------------------
module tgarle_core #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tgarle_pkg::byte_word_type word,
   input  logic                      out_free,
   input  logic [31:0]               pixel_total,
   input  logic [2:0]                pixel_bytes,
   output logic                      take,
   output logic                      emit,
   output tgarle_pkg::pixel_type     result
);

   logic                   expect_header_ff, expect_header_in;
   logic                   run_packet_ff, run_packet_in;
   logic [7:0]             left_ff, left_in;
   logic [1:0]             bip_ff, bip_in;
   logic [7:0]             buf_ff [3];
   logic [7:0]             buf_in [3];
   logic [COUNT_WIDTH-1:0] done_ff, done_in;

   logic                   four;
   logic [1:0]             last_pos;
   logic                   is_header;
   logic                   is_buffer;
   logic                   pixel_end;
   logic [1:0]             wr_idx;
   logic [7:0]             count;
   logic [7:0]             left_after;
   logic [COUNT_WIDTH-1:0] total;
   logic [COUNT_WIDTH:0]   sum;
   logic                   reach;
   logic [COUNT_WIDTH-1:0] missing;
   logic                   count_over;

   // classify the held byte
   assign four      = (pixel_bytes == tgarle_pkg::PIXEL_BYTES_RGBA);
   assign last_pos  = four ? 2'd3 : 2'd2;
   assign is_header = word.valid && expect_header_ff;
   assign is_buffer = word.valid && !expect_header_ff && (bip_ff < last_pos);
   assign pixel_end = word.valid && !expect_header_ff && !(bip_ff < last_pos);
   assign wr_idx    = bip_ff[0] ? 2'd1 : ((bip_ff > 2'd1) ? 2'd2 : 2'd0);

   // only a finishing pixel needs room in the result register
   assign emit = pixel_end;
   assign take = word.valid && (!pixel_end || out_free);

   // packet count for this pixel
   assign count      = run_packet_ff ? left_ff : 8'd1;
   assign left_after = run_packet_ff ? 8'd0 : (left_ff - 8'd1);

   // image pixel count against the total
   assign total      = pixel_total[COUNT_WIDTH-1:0];
   assign sum        = {1'b0, done_ff} + {{(COUNT_WIDTH-7){1'b0}}, count};
   assign reach      = (sum >= {1'b0, total});
   assign missing    = (total > done_ff) ? (total - done_ff) : '0;
   assign count_over = ({{(COUNT_WIDTH-8){1'b0}}, count} > missing);

   // result word
   always_comb begin
      result.red          = four ? buf_ff[2] : word.data;
      result.green        = buf_ff[1];
      result.blue         = buf_ff[0];
      result.alpha        = four ? word.data : 8'd0;
      result.repeat_count = (reach && count_over) ? missing[7:0] : count;
      result.last_pixel   = reach;
      result.overrun      = reach && (count_over || (left_after != 8'd0));
   end

   // next state
   always_comb begin
      expect_header_in = expect_header_ff;
      run_packet_in    = run_packet_ff;
      left_in          = left_ff;
      bip_in           = bip_ff;
      done_in          = done_ff;
      for (int i = 0; i < 3; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (take) begin
         if (is_header) begin
            run_packet_in    = word.data[7];
            left_in          = word.data[7] ? (word.data - tgarle_pkg::RUN_OFFSET)
                                            : (word.data + 8'd1);
            expect_header_in = 1'b0;
            bip_in           = 2'd0;
         end else if (is_buffer) begin
            for (int i = 0; i < 3; i++) begin
               if (wr_idx == 2'(i)) begin
                  buf_in[i] = word.data;
               end
            end
            bip_in = bip_ff + 2'd1;
         end else begin
            bip_in = 2'd0;
            if (reach) begin
               done_in          = '0;
               left_in          = 8'd0;
               expect_header_in = 1'b1;
            end else begin
               done_in          = sum[COUNT_WIDTH-1:0];
               left_in          = left_after;
               expect_header_in = (left_after == 8'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         run_packet_ff    <= 1'b0;
         left_ff          <= 8'd0;
         bip_ff           <= 2'd0;
         done_ff          <= '0;
         for (int i = 0; i < 3; i++) begin
            buf_ff[i] <= 8'd0;
         end
      end else begin
         expect_header_ff <= expect_header_in;
         run_packet_ff    <= run_packet_in;
         left_ff          <= left_in;
         bip_ff           <= bip_in;
         done_ff          <= done_in;
         for (int i = 0; i < 3; i++) begin
            buf_ff[i] <= buf_in[i];
         end
      end
   end

`ifndef ASSERT_OFF
   // inside a packet there is always at least one pixel left
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      !expect_header_ff |-> (left_ff != 8'd0))
      else $error("packet open with no pixels left");

   // an overrun only comes with the image end
   a_overrun_last: assert property (@(posedge clock) disable iff (reset)
      emit && result.overrun |-> result.last_pixel)
      else $error("overrun without image end");

   // a run never reports more than 128 pixels
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      emit |-> (result.repeat_count <= 8'd128))
      else $error("repeat count out of range");

   // after the image end the count restarts and a header follows
   a_image_restart: assert property (@(posedge clock) disable iff (reset)
      take && emit && result.last_pixel |=> expect_header_ff && (done_ff == '0))
      else $error("image end did not restart");
`endif

endmodule

>>> src/tgarle_out_stage.sv
// ---------------------------------------------------------------------------
// tgarle_out_stage
// Result register: holds one pixel result until the receiver takes it.
// ---------------------------------------------------------------------------
module tgarle_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tgarle_pkg::pixel_type result,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tgarle_pkg::pixel_type rsp_word
);

   logic                  valid_ff, valid_in;
   tgarle_pkg::pixel_type word_ff, word_in;

   // room when empty or when the held word leaves this cycle
   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);
   assign word_in  = load ? result : word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

>>> src/tga_rle_pixel_decoder.sv
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA run-length pixel stream decoder, one coded byte per word.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one coded byte per word (packet headers and pixel bytes).
//   rsp_*  : one pixel per word as red/green/blue/alpha plus a repeat count;
//            a run leaves as a single word. last_pixel marks the word that
//            completes the image, overrun marks a packet clipped at its end.
//   csr_*  : index 0 is the image pixel total, index 1 the bytes per pixel
//            (4 for RGBA, anything else RGB). Write only while idle.
// Path: the byte that finishes a pixel passes the input register, then the
//   result register, before rsp_valid rises.
// Throughput: one byte per cycle while rsp is not held, set by the
//   single-pass step between the input register and the result register.
// Reset: expects a packet header, pixel count zero, total 1, three-byte
//   pixels.
// Stall: while rsp is held, header and leading pixel bytes still flow;
//   a byte that finishes a pixel waits in the input register, and req_ready
//   drops once that register is also full.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_last_pixel,
   output logic        rsp_overrun,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [tgarle_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic [31:0]               pixel_total_ff, pixel_total_in;
   logic [2:0]                pixel_bytes_ff, pixel_bytes_in;
   tgarle_pkg::byte_word_type word;
   tgarle_pkg::pixel_type     result;
   tgarle_pkg::pixel_type     rsp_word;
   logic                      take;
   logic                      emit;
   logic                      out_free;

   // configuration registers
   always_comb begin
      pixel_total_in = pixel_total_ff;
      pixel_bytes_in = pixel_bytes_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tgarle_pkg::CSR_PIXEL_TOTAL: pixel_total_in = csr_wdata[31:0];
            tgarle_pkg::CSR_PIXEL_BYTES: pixel_bytes_in = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_total_ff <= tgarle_pkg::PIXEL_TOTAL_RESET;
         pixel_bytes_ff <= tgarle_pkg::PIXEL_BYTES_RESET;
      end else begin
         pixel_total_ff <= pixel_total_in;
         pixel_bytes_ff <= pixel_bytes_in;
      end
   end

   tgarle_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .take          (take),
      .word          (word)
   );

   tgarle_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .word        (word),
      .out_free    (out_free),
      .pixel_total (pixel_total_ff),
      .pixel_bytes (pixel_bytes_ff),
      .take        (take),
      .emit        (emit),
      .result      (result)
   );

   tgarle_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take && emit),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_red          = rsp_word.red;
   assign rsp_green        = rsp_word.green;
   assign rsp_blue         = rsp_word.blue;
   assign rsp_alpha        = rsp_word.alpha;
   assign rsp_repeat_count = rsp_word.repeat_count;
   assign rsp_last_pixel   = rsp_word.last_pixel;
   assign rsp_overrun      = rsp_word.overrun;

endmodule

>>> test/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder
// Self-checking bench for the TGA run-length pixel decoder. Coded bytes go
// in with bursty valid timing while the pixel side stalls in shifting
// patterns. A software decoder follows every accepted byte, queues the
// pixel words it should produce, and each pixel word leaving the block is
// compared against the oldest queued one. Directed packets cover the field
// extremes, runs, raw packets, clipping at the image end and a zero pixel
// total. Random images follow over several register settings.
// ---------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder;

   localparam logic [7:0]  RUN_HEADER_MIN = 8'd128;
   localparam int unsigned PHASE_BYTES    = 210;
   localparam int unsigned PHASE_COUNT    = 9;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned CYCLE_LIMIT    = 400000;

   // Software decoder: mirrors the block state and queues expected pixel words
   class rle_pixel_tracker;
      logic [31:0]           cfg_total;
      logic [2:0]            cfg_bytes;
      bit                    want_header;
      bit                    is_run;
      logic [7:0]            left;
      logic [1:0]            pos;
      logic [7:0]            stored [3];
      logic [31:0]           done;
      tgarle_pkg::pixel_type pending_pixels [$];
      int unsigned           mismatches;
      int unsigned           pixel_words;

      function new();
         cfg_total   = tgarle_pkg::PIXEL_TOTAL_RESET;
         cfg_bytes   = tgarle_pkg::PIXEL_BYTES_RESET;
         want_header = 1'b1;
         is_run      = 1'b0;
         left        = 8'd0;
         pos         = 2'd0;
         foreach (stored[i]) stored[i] = 8'd0;
         done        = 32'd0;
         mismatches  = 0;
         pixel_words = 0;
      endfunction

      function void set_reg(input logic index, input logic [31:0] value);
         if (index == tgarle_pkg::CSR_PIXEL_TOTAL) cfg_total = value;
         else cfg_bytes = value[2:0];
      endfunction

      function void take_byte(input logic [7:0] b);
         logic [1:0]            final_pos;
         logic [7:0]            count;
         logic [31:0]           missing;
         logic [32:0]           reach;
         tgarle_pkg::pixel_type px;
         final_pos = (cfg_bytes == tgarle_pkg::PIXEL_BYTES_RGBA) ? 2'd3 : 2'd2;
         // packet header
         if (want_header) begin
            is_run      = (b >= RUN_HEADER_MIN);
            left        = is_run ? b - tgarle_pkg::RUN_OFFSET : b + 8'd1;
            want_header = 1'b0;
            pos         = 2'd0;
            return;
         end
         // leading bytes of a pixel are only buffered
         if (pos < final_pos) begin
            stored[pos] = b;
            pos = pos + 2'd1;
            return;
         end
         pos = 2'd0;
         px.red   = (final_pos == 2'd3) ? stored[2] : b;
         px.green = stored[1];
         px.blue  = stored[0];
         px.alpha = (final_pos == 2'd3) ? b : 8'd0;
         if (is_run) begin
            count = left;
            left  = 8'd0;
         end else begin
            count = 8'd1;
            left  = left - 8'd1;
         end
         missing = (cfg_total > done) ? cfg_total - done : 32'd0;
         reach   = {1'b0, done} + 33'(count);
         px.repeat_count = count;
         px.last_pixel   = 1'b0;
         px.overrun      = 1'b0;
         // image end: clip, flag overrun, restart at a header
         if (reach >= {1'b0, cfg_total}) begin
            px.last_pixel = 1'b1;
            if (32'(count) > missing) begin
               px.repeat_count = missing[7:0];
               px.overrun      = 1'b1;
            end
            if (left != 8'd0) px.overrun = 1'b1;
            done        = 32'd0;
            left        = 8'd0;
            want_header = 1'b1;
         end else begin
            done = reach[31:0];
            if (left == 8'd0) want_header = 1'b1;
         end
         pending_pixels = {pending_pixels, px};
      endfunction

      task report(input string msg);
         mismatches++;
         $display("[%0t] MISMATCH %s", $realtime, msg);
      endtask

      task match_pixel(input tgarle_pkg::pixel_type got);
         tgarle_pkg::pixel_type want;
         if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected pixel word %h", got));
            return;
         end
         want = pending_pixels.pop_front();
         pixel_words++;
         if (got !== want)
            report($sformatf({"word %0d: got rgba %h %h %h %h x%0d last %b over %b,",
                              " expected rgba %h %h %h %h x%0d last %b over %b"},
                             pixel_words, got.red, got.green, got.blue, got.alpha,
                             got.repeat_count, got.last_pixel, got.overrun,
                             want.red, want.green, want.blue, want.alpha,
                             want.repeat_count, want.last_pixel, want.overrun));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_count;
   logic        rsp_last_pixel;
   logic        rsp_overrun;
   logic        csr_write_en = 1'b0;
   logic        csr_index = tgarle_pkg::CSR_PIXEL_TOTAL;
   logic [tgarle_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   rle_pixel_tracker tracker;
   int unsigned burst_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned settings   = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_span = 0;
   int unsigned cycle_count = 0;

   tga_rle_pixel_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last_pixel   (rsp_last_pixel),
      .rsp_overrun      (rsp_overrun),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // pixel side: check accepted words, stall in changing patterns
   always @(posedge clock) begin : pixel_side
      tgarle_pkg::pixel_type seen;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_repeat_count,
                    rsp_last_pixel, rsp_overrun};
            tracker.match_pixel(seen);
         end
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(8, 64);
         end else begin
            stall_span--;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 9) < 7);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // one coded byte, sent in bursts with random gaps between them
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      tracker.take_byte(b);
   endtask

   // wait until every pixel word is out and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [31:0] total, input logic [2:0] size);
      csr_write_en <= 1'b1;
      csr_index    <= tgarle_pkg::CSR_PIXEL_TOTAL;
      csr_wdata    <= total;
      @(posedge clock);
      tracker.set_reg(tgarle_pkg::CSR_PIXEL_TOTAL, total);
      csr_index    <= tgarle_pkg::CSR_PIXEL_BYTES;
      csr_wdata    <= 32'(size);
      @(posedge clock);
      tracker.set_reg(tgarle_pkg::CSR_PIXEL_BYTES, 32'(size));
      csr_write_en <= 1'b0;
      settings++;
   endtask

   // mostly well-formed packets sized to the pixels still missing, some noise
   task automatic run_stream(input int unsigned count);
      logic [7:0]  b;
      logic [31:0] missing;
      int unsigned span;
      repeat (count) begin
         b = 8'($urandom);
         if (tracker.want_header && $urandom_range(0, 99) < 85) begin
            missing = (tracker.cfg_total > tracker.done) ?
                      tracker.cfg_total - tracker.done : 32'd0;
            if (missing == 0 || missing > 128 || $urandom_range(0, 3) == 0)
               span = $urandom_range(1, 128);
            else
               span = $urandom_range(1, missing);
            if ($urandom_range(0, 3) != 0 && span > 8) span = $urandom_range(1, 8);
            b = $urandom_range(0, 1) ? 8'(span - 1) : 8'(span + 127);
         end
         send_byte(b);
      end
   endtask

   initial begin
      logic [7:0]  seq [$];
      logic [31:0] total;
      logic [2:0]  size;
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, one-pixel images: exact fit, raw overrun, run overrun
      seq = '{8'h00, 8'hFF, 8'h00, 8'h80,
              8'h01, 8'h11, 8'h22, 8'h33,
              8'h81, 8'h44, 8'h55, 8'h66};
      foreach (seq[i]) send_byte(seq[i]);
      settle();

      // largest total, RGBA: longest run
      write_regs(32'hFFFF_FFFF, tgarle_pkg::PIXEL_BYTES_RGBA);
      seq = '{8'hFF, 8'h01, 8'h02, 8'h03, 8'h04};
      foreach (seq[i]) send_byte(seq[i]);
      settle();

      // zero total, odd size code meaning RGB
      write_regs(32'd0, 3'd7);
      seq = '{8'h80, 8'h12, 8'h34, 8'h56};
      foreach (seq[i]) send_byte(seq[i]);
      settle();

      // random images over a spread of settings
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin total = $urandom_range(1, 40);   size = 3'd3; end
            1: begin total = 32'd1;  size = tgarle_pkg::PIXEL_BYTES_RGBA; end
            2: begin
               total = $urandom_range(50, 400);
               size  = tgarle_pkg::PIXEL_BYTES_RGBA;
            end
            3: begin total = 32'hFFFF_FFFF;           size = 3'd3;         end
            4: begin total = 32'd0;                   size = 3'($urandom); end
            5: begin total = $urandom_range(1, 400);  size = 3'd0;         end
            6: begin total = $urandom_range(2, 20);   size = 3'd7;         end
            7: begin total = $urandom_range(1, 400);  size = 3'($urandom); end
            default: begin
               total = $urandom_range(1, 4000);
               size  = tgarle_pkg::PIXEL_BYTES_RGBA;
            end
         endcase
         write_regs(total, size);
         run_stream(PHASE_BYTES);
         settle();
      end

      if (tracker.pending_pixels.size() != 0)
         tracker.report($sformatf("%0d pixel words never arrived",
                                  tracker.pending_pixels.size()));
      $display("decoded %0d coded bytes into %0d pixel words under %0d register settings",
               bytes_sent, tracker.pixel_words, settings + 1);
      $display("mismatches: %0d", tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
